[sv/triangle_raster_zbuffer_core_macros.svh]
// ----------------------------------------------------------------------------
// Triangle raster z-buffer core: assertion macros
// Concurrent checks used by the rasterizer RTL, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_RASTER_ZBUFFER_CORE_MACROS_SVH
`define TRIANGLE_RASTER_ZBUFFER_CORE_MACROS_SVH

// same-cycle implication
`define TRZ_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TRZ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/trz_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle raster z-buffer package
// Shared widths, constants, operation codes and divider status type.
// ----------------------------------------------------------------------------
package trz_pkg;

	localparam int TILE_SIZE_DEF = 128;

	// field widths
	localparam int COORD_IN_W = 16;
	localparam int DEPTH_W    = 16;
	localparam int RC_W       = 7;
	localparam int COLOR_W    = 8;
	localparam int COUNT_W    = 15;

	// stream widths
	localparam int IN_DATA_W  = 160;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_USER_W = 1;

	// arithmetic widths
	localparam int NUM_W   = 64;
	localparam int DEN_W   = 36;
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 18;
	localparam int EDGE_W  = 48;
	localparam int WORD_W  = DEPTH_W + 3 * COLOR_W;

	localparam logic [DEPTH_W-1:0] FAR_DEPTH = 16'hFFFF;
	localparam int COLOR_SUM   = 303;
	localparam int COLOR_RANGE = 231;
	localparam int COLOR_BASE  = 24;
	localparam int FIX_ONE     = 256;
	localparam int MIN_AREA    = 4;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[sv/trz_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module trz_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/trz_div.sv]
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring divide, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module trz_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [trz_pkg::NUM_W-1:0] num,
	input  logic [trz_pkg::DEN_W-1:0]       den,
	output trz_pkg::div_stat_t              stat,
	output logic signed [trz_pkg::NUM_W-1:0] quo
);
	import trz_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             neg_q;
	logic [NUM_W-1:0] mag_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	// shift in the next dividend bit and trial subtract
	assign rem_sh = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			quo_q <= '0;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			mag_q <= {mag_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sh - {1'b0, den} : rem_sh;
		end
	end

	assign quo       = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

[sv/triangle_raster_zbuffer_core.sv]
// ----------------------------------------------------------------------------
// Triangle raster z-buffer core
// Edge-function triangle rasterizer with depth test over one square tile.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields
// s_*      in   tuser: operation; tdata: corners, depths, read column/row
// m_*      out  tuser: triangle_skipped; tdata: red, green, blue, pixels_drawn
//
// Clear: all TILE_SIZE*TILE_SIZE words, one RAM word per cycle.
// Read: one registered RAM read. Triangle: shared-multiplier setup,
// 9 divisions on the serial divider, then for each pixel of the clipped
// box a RAM read, then compare and write.
// After reset a clearing pass over all TILE_SIZE*TILE_SIZE words runs with
// s_tready low. One request is worked at a time; a finished result waits in
// the output register while the next request is taken.
// ----------------------------------------------------------------------------
module triangle_raster_zbuffer_core #(
	parameter int TILE_SIZE = trz_pkg::TILE_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y,
	// corner_a_depth, corner_b_depth, corner_c_depth, read_column, read_row
	input  logic [trz_pkg::IN_DATA_W-1:0]      s_tdata,
	// operation
	input  logic [trz_pkg::IN_USER_W-1:0]      s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pixel_red, pixel_green, pixel_blue, pixels_drawn
	output logic [trz_pkg::OUT_DATA_W-1:0]     m_tdata,
	// triangle_skipped
	output logic [trz_pkg::OUT_USER_W-1:0]     m_tuser
);
	import trz_pkg::*;
	`include "triangle_raster_zbuffer_core_macros.svh"

	localparam int COORD_W = $clog2(TILE_SIZE);
	localparam int NPIX    = TILE_SIZE * TILE_SIZE;
	localparam int ADDR_W  = $clog2(NPIX);
	localparam int NDIV    = 9;
	localparam int DK_W    = $clog2(NDIV);
	localparam logic [4:0] MK_AREA_END = 5'd1;
	localparam logic [4:0] MK_LAST     = 5'd19;
	localparam logic signed [16:0] TMAX = 17'(TILE_SIZE - 1);
	localparam logic signed [MUL_B_W-1:0] CR = MUL_B_W'(COLOR_RANGE * FIX_ONE);
	localparam logic signed [NUM_W-1:0] CBASE = NUM_W'(COLOR_BASE * FIX_ONE);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_CLEAR  = 11'b000_0000_0010,
		S_MUL    = 11'b000_0000_0100,
		S_ORDER  = 11'b000_0000_1000,
		S_DIV    = 11'b000_0001_0000,
		S_DIVW   = 11'b000_0010_0000,
		S_PIX_RD = 11'b000_0100_0000,
		S_PIX_WR = 11'b000_1000_0000,
		S_READ   = 11'b001_0000_0000,
		S_READW  = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
		logic signed [15:0] m;
		m = (a < b) ? a : b;
		return (c < m) ? c : m;
	endfunction

	function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
		logic signed [15:0] m;
		m = (a > b) ? a : b;
		return (c > m) ? c : m;
	endfunction

	// ---------------- registers ----------------
	state_t               state_q;
	logic [ADDR_W-1:0]    clr_cnt_q;
	logic                 clr_item_q;
	logic [4:0]           mk_q;
	logic                 mph_q;
	logic [DK_W-1:0]      dk_q;
	logic                 m_tvalid_q;

	logic signed [15:0]   ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [DEPTH_W-1:0]   za_q, zb_q, zc_q;
	logic [RC_W-1:0]      rd_col_q, rd_row_q;
	logic                 rd_ok_q;
	logic signed [MUL_A_W+MUL_B_W-1:0] p_s1;
	logic signed [MUL_A_W+MUL_B_W:0]   acc_q;
	logic signed [DEN_W-1:0]           area_q;
	logic [COORD_W-1:0]   x0_q, x1_q, y0_q, y1_q, px_q, py_q;
	logic signed [EDGE_W-1:0] w0_q, w1_q, w2_q, w0r_q, w1r_q, w2r_q;
	logic signed [NUM_W-1:0]  num_q [NDIV];
	logic signed [NUM_W-1:0]  dzdx_q, dzdy_q, drdx_q, drdy_q, dgdx_q, dgdy_q;
	logic signed [NUM_W-1:0]  z_q, zr_q, r_q, rr_q, g_q, gr_q;
	logic [ADDR_W-1:0]    addr_q, row_addr_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [COLOR_W-1:0]   res_red_q, res_green_q, res_blue_q;
	logic [COUNT_W-1:0]   res_drawn_q;
	logic                 res_skip_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	// ---------------- request fields ----------------
	logic s_fire;
	op_t  s_op;
	assign s_fire   = s_tvalid && s_tready;
	assign s_op     = op_t'(s_tuser);
	assign s_tready = (state_q == S_IDLE);

	// ---------------- corner differences ----------------
	logic signed [16:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e, x0_e, y0_e;
	logic signed [16:0] a12, b12, a20, b20, a01, b01, dzb, dzc;
	assign ax_e = 17'(ax_q);
	assign ay_e = 17'(ay_q);
	assign bx_e = 17'(bx_q);
	assign by_e = 17'(by_q);
	assign cx_e = 17'(cx_q);
	assign cy_e = 17'(cy_q);
	assign x0_e = 17'($signed({1'b0, x0_q}));
	assign y0_e = 17'($signed({1'b0, y0_q}));
	assign a12  = by_e - cy_e;
	assign b12  = cx_e - bx_e;
	assign a20  = cy_e - ay_e;
	assign b20  = ax_e - cx_e;
	assign a01  = ay_e - by_e;
	assign b01  = bx_e - ax_e;
	assign dzb  = $signed({1'b0, zb_q}) - $signed({1'b0, za_q});
	assign dzc  = $signed({1'b0, zc_q}) - $signed({1'b0, za_q});

	// ---------------- shared multiplier operand select ----------------
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (mk_q)
			5'd0:  begin mul_a = MUL_A_W'(b01);         mul_b = MUL_B_W'(a20);         end
			5'd1:  begin mul_a = MUL_A_W'(-b20);        mul_b = MUL_B_W'(-a01);        end
			5'd2:  begin mul_a = MUL_A_W'(bx_e - x0_e); mul_b = MUL_B_W'(cy_e - y0_e); end
			5'd3:  begin mul_a = MUL_A_W'(cx_e - x0_e); mul_b = MUL_B_W'(by_e - y0_e); end
			5'd4:  begin mul_a = MUL_A_W'(cx_e - x0_e); mul_b = MUL_B_W'(ay_e - y0_e); end
			5'd5:  begin mul_a = MUL_A_W'(ax_e - x0_e); mul_b = MUL_B_W'(cy_e - y0_e); end
			5'd6:  begin mul_a = MUL_A_W'(ax_e - x0_e); mul_b = MUL_B_W'(by_e - y0_e); end
			5'd7:  begin mul_a = MUL_A_W'(bx_e - x0_e); mul_b = MUL_B_W'(ay_e - y0_e); end
			5'd8:  begin mul_a = MUL_A_W'(a20);         mul_b = MUL_B_W'(dzb);         end
			5'd9:  begin mul_a = MUL_A_W'(a01);         mul_b = MUL_B_W'(dzc);         end
			5'd10: begin mul_a = MUL_A_W'(b20);         mul_b = MUL_B_W'(dzb);         end
			5'd11: begin mul_a = MUL_A_W'(b01);         mul_b = MUL_B_W'(dzc);         end
			5'd12: begin mul_a = MUL_A_W'(w1r_q);       mul_b = MUL_B_W'(dzb);         end
			5'd13: begin mul_a = MUL_A_W'(w2r_q);       mul_b = MUL_B_W'(dzc);         end
			5'd14: begin mul_a = MUL_A_W'(a12);         mul_b = CR;                    end
			5'd15: begin mul_a = MUL_A_W'(b12);         mul_b = CR;                    end
			5'd16: begin mul_a = MUL_A_W'(a20);         mul_b = CR;                    end
			5'd17: begin mul_a = MUL_A_W'(b20);         mul_b = CR;                    end
			5'd18: begin mul_a = MUL_A_W'(w0r_q);       mul_b = CR;                    end
			5'd19: begin mul_a = MUL_A_W'(w1r_q);       mul_b = CR;                    end
			default: begin mul_a = '0;                  mul_b = '0;                    end
		endcase
	end

	// ---------------- winding order and clipped box ----------------
	logic                    area_neg, tri_small, box_empty;
	logic signed [DEN_W-1:0] area_mag;
	logic signed [16:0]      bx0, by0, bx1, by1;
	logic signed [15:0]      lo_x, lo_y, hi_x, hi_y;
	assign area_neg  = area_q[DEN_W-1];
	assign area_mag  = area_neg ? -area_q : area_q;
	assign tri_small = area_mag < DEN_W'(MIN_AREA);
	assign lo_x      = min3(ax_q, bx_q, cx_q);
	assign lo_y      = min3(ay_q, by_q, cy_q);
	assign hi_x      = max3(ax_q, bx_q, cx_q);
	assign hi_y      = max3(ay_q, by_q, cy_q);
	assign bx0       = (lo_x < 16'sd0) ? 17'sd0 : 17'(lo_x);
	assign by0       = (lo_y < 16'sd0) ? 17'sd0 : 17'(lo_y);
	assign bx1       = (17'(hi_x) > TMAX) ? TMAX : 17'(hi_x);
	assign by1       = (17'(hi_y) > TMAX) ? TMAX : 17'(hi_y);
	assign box_empty = (bx0 > bx1) || (by0 > by1);

	// ---------------- divider ----------------
	div_stat_t               div_stat;
	logic signed [NUM_W-1:0] div_quo;
	logic                    div_start;
	assign div_start = (state_q == S_DIV);

	trz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q[dk_q]),
		.den    (DEN_W'(area_q)),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	// ---------------- pixel test ----------------
	logic [WORD_W-1:0]  mem_rdata, mem_wdata;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr, rd_addr, init_row;
	logic               mem_we, in_tri, nearer, hit, last_col, last_row;
	logic [COLOR_W-1:0] pr, pg, pb;
	logic signed [EDGE_W-1:0] a12_e, b12_e, a20_e, b20_e, a01_e, b01_e;

	assign in_tri = !w0_q[EDGE_W-1] && !w1_q[EDGE_W-1] && !w2_q[EDGE_W-1] && !z_q[NUM_W-1];
	assign nearer = (z_q[NUM_W-1:24] == '0)
		&& (z_q[23:8] < mem_rdata[WORD_W-1 -: DEPTH_W]);
	assign hit    = (state_q == S_PIX_WR) && in_tri && nearer;
	assign pr     = r_q[15:8];
	assign pg     = g_q[15:8];
	assign pb     = COLOR_W'(COLOR_SUM) - pr - pg;
	assign a12_e  = EDGE_W'(a12);
	assign b12_e  = EDGE_W'(b12);
	assign a20_e  = EDGE_W'(a20);
	assign b20_e  = EDGE_W'(b20);
	assign a01_e  = EDGE_W'(a01);
	assign b01_e  = EDGE_W'(b01);
	assign last_col = (px_q == x1_q);
	assign last_row = (py_q == y1_q);

	assign rd_addr  = ADDR_W'(32'(rd_row_q) * 32'(TILE_SIZE) + 32'(rd_col_q));
	assign init_row = ADDR_W'(32'(y0_q) * 32'(TILE_SIZE));

	// ---------------- tile memory ----------------
	assign mem_we    = (state_q == S_CLEAR) || hit;
	assign mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q : addr_q;
	assign mem_wdata = (state_q == S_CLEAR) ? {FAR_DEPTH, {(3 * COLOR_W){1'b0}}}
		: {z_q[23:8], pr, pg, pb};
	assign mem_raddr = (state_q == S_PIX_RD) ? addr_q : rd_addr;

	trz_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NPIX)
	) u_tile (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// ---------------- sequencer ----------------
	logic out_load;
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_cnt_q  <= '0;
			clr_item_q <= 1'b0;
			mk_q       <= '0;
			mph_q      <= 1'b0;
			dk_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						case (s_op)
							OP_CLEAR: begin
								state_q    <= S_CLEAR;
								clr_cnt_q  <= '0;
								clr_item_q <= 1'b1;
							end
							OP_DRAW: begin
								state_q <= S_MUL;
								mk_q    <= '0;
								mph_q   <= 1'b0;
							end
							OP_READ: state_q <= S_READ;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == ADDR_W'(NPIX - 1)) begin
						state_q <= clr_item_q ? S_OUT : S_IDLE;
					end
				end
				S_MUL: begin
					mph_q <= !mph_q;
					if (mph_q) begin
						mk_q <= mk_q + 1'b1;
						if (mk_q == MK_AREA_END) begin
							state_q <= S_ORDER;
						end else if (mk_q == MK_LAST) begin
							state_q <= S_DIV;
							dk_q    <= '0;
						end
					end
				end
				S_ORDER: begin
					state_q <= (tri_small || box_empty) ? S_OUT : S_MUL;
					mph_q   <= 1'b0;
				end
				S_DIV: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_stat.done) begin
						if (dk_q == DK_W'(NDIV - 1)) begin
							state_q <= S_PIX_RD;
						end else begin
							dk_q    <= dk_q + 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_PIX_RD: state_q <= S_PIX_WR;
				S_PIX_WR: state_q <= (last_col && last_row) ? S_OUT : S_PIX_RD;
				S_READ:   state_q <= S_READW;
				S_READW:  state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q    <= S_IDLE;
						clr_item_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		// request capture
		if (s_fire) begin
			ax_q        <= s_tdata[15:0];
			ay_q        <= s_tdata[31:16];
			bx_q        <= s_tdata[47:32];
			by_q        <= s_tdata[63:48];
			cx_q        <= s_tdata[79:64];
			cy_q        <= s_tdata[95:80];
			za_q        <= s_tdata[111:96];
			zb_q        <= s_tdata[127:112];
			zc_q        <= s_tdata[143:128];
			rd_col_q    <= s_tdata[150:144];
			rd_row_q    <= s_tdata[157:151];
			rd_ok_q     <= (32'(s_tdata[150:144]) < TILE_SIZE)
				&& (32'(s_tdata[157:151]) < TILE_SIZE);
			res_red_q   <= '0;
			res_green_q <= '0;
			res_blue_q  <= '0;
			res_drawn_q <= '0;
			res_skip_q  <= 1'b0;
			cnt_q       <= '0;
		end

		// shared multiplier: issue, then fold the product
		if (state_q == S_MUL) begin
			if (!mph_q) begin
				p_s1 <= mul_a * mul_b;
			end else begin
				case (mk_q)
					5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12:
						acc_q <= (MUL_A_W+MUL_B_W+1)'(p_s1);
					5'd1: area_q <= DEN_W'(acc_q - p_s1);
					5'd3: begin w0r_q <= EDGE_W'(acc_q - p_s1); w0_q <= EDGE_W'(acc_q - p_s1); end
					5'd5: begin w1r_q <= EDGE_W'(acc_q - p_s1); w1_q <= EDGE_W'(acc_q - p_s1); end
					5'd7: begin w2r_q <= EDGE_W'(acc_q - p_s1); w2_q <= EDGE_W'(acc_q - p_s1); end
					5'd9:  num_q[0] <= (NUM_W'(acc_q) + NUM_W'(p_s1)) <<< 8;
					5'd11: num_q[1] <= (NUM_W'(acc_q) + NUM_W'(p_s1)) <<< 8;
					5'd13: num_q[2] <= (NUM_W'(acc_q) + NUM_W'(p_s1)) <<< 8;
					5'd14: num_q[3] <= NUM_W'(p_s1);
					5'd15: num_q[4] <= NUM_W'(p_s1);
					5'd16: num_q[5] <= NUM_W'(p_s1);
					5'd17: num_q[6] <= NUM_W'(p_s1);
					5'd18: num_q[7] <= NUM_W'(p_s1);
					5'd19: num_q[8] <= NUM_W'(p_s1);
					default: acc_q <= acc_q;
				endcase
			end
		end

		// positive winding, clipped box
		if (state_q == S_ORDER) begin
			if (area_neg) begin
				bx_q <= cx_q;
				by_q <= cy_q;
				cx_q <= bx_q;
				cy_q <= by_q;
				zb_q <= zc_q;
				zc_q <= zb_q;
			end
			area_q     <= area_mag;
			x0_q       <= bx0[COORD_W-1:0];
			y0_q       <= by0[COORD_W-1:0];
			x1_q       <= bx1[COORD_W-1:0];
			y1_q       <= by1[COORD_W-1:0];
			res_skip_q <= tri_small || box_empty;
		end

		// quotients into slopes and starts
		if (state_q == S_DIVW && div_stat.done) begin
			case (dk_q)
				4'd0: dzdx_q <= div_quo;
				4'd1: dzdy_q <= div_quo;
				4'd2: begin
					zr_q <= (NUM_W'(za_q) <<< 8) + div_quo;
					z_q  <= (NUM_W'(za_q) <<< 8) + div_quo;
				end
				4'd3: drdx_q <= div_quo;
				4'd4: drdy_q <= div_quo;
				4'd5: dgdx_q <= div_quo;
				4'd6: dgdy_q <= div_quo;
				4'd7: begin
					rr_q <= CBASE + div_quo;
					r_q  <= CBASE + div_quo;
				end
				4'd8: begin
					gr_q       <= CBASE + div_quo;
					g_q        <= CBASE + div_quo;
					px_q       <= x0_q;
					py_q       <= y0_q;
					row_addr_q <= init_row;
					addr_q     <= init_row + ADDR_W'(x0_q);
				end
				default: dzdx_q <= dzdx_q;
			endcase
		end

		// walk one pixel
		if (state_q == S_PIX_WR) begin
			if (hit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (last_col) begin
				if (last_row) begin
					res_drawn_q <= hit ? cnt_q + 1'b1 : cnt_q;
				end else begin
					py_q       <= py_q + 1'b1;
					px_q       <= x0_q;
					w0r_q      <= w0r_q + b12_e;
					w1r_q      <= w1r_q + b20_e;
					w2r_q      <= w2r_q + b01_e;
					w0_q       <= w0r_q + b12_e;
					w1_q       <= w1r_q + b20_e;
					w2_q       <= w2r_q + b01_e;
					zr_q       <= zr_q + dzdy_q;
					rr_q       <= rr_q + drdy_q;
					gr_q       <= gr_q + dgdy_q;
					z_q        <= zr_q + dzdy_q;
					r_q        <= rr_q + drdy_q;
					g_q        <= gr_q + dgdy_q;
					row_addr_q <= row_addr_q + ADDR_W'(TILE_SIZE);
					addr_q     <= row_addr_q + ADDR_W'(TILE_SIZE) + ADDR_W'(x0_q);
				end
			end else begin
				px_q   <= px_q + 1'b1;
				w0_q   <= w0_q + a12_e;
				w1_q   <= w1_q + a20_e;
				w2_q   <= w2_q + a01_e;
				z_q    <= z_q + dzdx_q;
				r_q    <= r_q + drdx_q;
				g_q    <= g_q + dgdx_q;
				addr_q <= addr_q + 1'b1;
			end
		end

		// pixel read
		if (state_q == S_READW && rd_ok_q) begin
			res_red_q   <= mem_rdata[23:16];
			res_green_q <= mem_rdata[15:8];
			res_blue_q  <= mem_rdata[7:0];
		end

		// result register
		if (out_load) begin
			out_data_q <= {1'b0, res_drawn_q, res_blue_q, res_green_q, res_red_q};
			out_user_q <= res_skip_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// ---------------- assertions ----------------
	`TRZ_ASSERT(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
	`TRZ_ASSERT(a_ready_div_idle, s_tready, !div_stat.busy, "request taken during a division")
	`TRZ_ASSERT(a_done_in_wait, div_stat.done, state_q == S_DIVW, "quotient with no waiter")
	`TRZ_ASSERT(a_walk_in_box, state_q == S_PIX_RD, (px_q <= x1_q) && (py_q <= y1_q),
		"pixel walk left the box")
	`TRZ_ASSERT_NEXT(a_out_load, out_load, m_tvalid, "loaded result not presented")

endmodule

[dv/triangle_raster_zbuffer_core_checker.sv]
// ----------------------------------------------------------------------------
// Triangle raster z-buffer checker
// Watches both stream channels and keeps its own depth and color tile.
// Each accepted draw request is rasterized here with the same fixed-point planes.
// Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module triangle_raster_zbuffer_core_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [trz_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [trz_pkg::IN_USER_W-1:0] s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [trz_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [trz_pkg::OUT_USER_W-1:0] m_tuser,
	output int                            errors,
	output int                            pending
);
	import trz_pkg::*;

	localparam int TILE = TILE_SIZE_DEF;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [14:0] drawn;
		logic        skipped;
	} pixel_result_t;

	logic [15:0] depth_tile [TILE*TILE];
	logic [23:0] color_tile [TILE*TILE];
	pixel_result_t result_q [$];

	assign pending = result_q.size();

	task automatic report(input string field, input longint want, input longint got);
		$display("mismatch on %s: expected %0d, got %0d", field, want, got);
		errors++;
	endtask

	task automatic clear_tile();
		for (int i = 0; i < TILE * TILE; i++) begin
			depth_tile[i] = FAR_DEPTH;
			color_tile[i] = '0;
		end
	endtask

	function automatic longint min3(input longint a, input longint b, input longint c);
		longint m;
		m = a < b ? a : b;
		return c < m ? c : m;
	endfunction

	function automatic longint max3(input longint a, input longint b, input longint c);
		longint m;
		m = a > b ? a : b;
		return c > m ? c : m;
	endfunction

	// rasterize one triangle into the shadow tile; -1 when skipped
	task automatic rasterize(input logic [IN_DATA_W-1:0] d, output longint count);
		longint ax, ay, bx, by, cx, cy, za, zb, zc, area, t;
		longint x0, y0, x1, y1, cr;
		longint a12, b12, a20, b20, a01, b01, w0r, w1r, w2r;
		longint dzdx, dzdy, zr, drdx, drdy, dgdx, dgdy, rr, gr;
		longint w0, w1, w2, zf, rf, gf, zq;
		logic [7:0] r, g, b;
		int idx;
		ax = $signed(d[15:0]);    ay = $signed(d[31:16]);
		bx = $signed(d[47:32]);   by = $signed(d[63:48]);
		cx = $signed(d[79:64]);   cy = $signed(d[95:80]);
		za = d[111:96];           zb = d[127:112];         zc = d[143:128];
		cr = COLOR_RANGE * FIX_ONE;
		count = 0;
		area = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
		// keep the winding positive
		if (area < 0) begin
			t = bx; bx = cx; cx = t;
			t = by; by = cy; cy = t;
			t = zb; zb = zc; zc = t;
			area = -area;
		end
		if (area < MIN_AREA) begin
			count = -1;
			return;
		end
		x0 = min3(ax, bx, cx); if (x0 < 0) x0 = 0;
		y0 = min3(ay, by, cy); if (y0 < 0) y0 = 0;
		x1 = max3(ax, bx, cx); if (x1 > TILE - 1) x1 = TILE - 1;
		y1 = max3(ay, by, cy); if (y1 > TILE - 1) y1 = TILE - 1;
		if (x0 > x1 || y0 > y1) begin
			count = -1;
			return;
		end
		a12 = by - cy; b12 = cx - bx;
		a20 = cy - ay; b20 = ax - cx;
		a01 = ay - by; b01 = bx - ax;
		w0r = (bx - x0) * (cy - y0) - (cx - x0) * (by - y0);
		w1r = (cx - x0) * (ay - y0) - (ax - x0) * (cy - y0);
		w2r = (ax - x0) * (by - y0) - (bx - x0) * (ay - y0);
		// plane setup, truncating toward zero
		dzdx = ((zb - za) * a20 + (zc - za) * a01) * FIX_ONE / area;
		dzdy = ((zb - za) * b20 + (zc - za) * b01) * FIX_ONE / area;
		zr = za * FIX_ONE + ((zb - za) * w1r + (zc - za) * w2r) * FIX_ONE / area;
		drdx = cr * a12 / area;
		drdy = cr * b12 / area;
		dgdx = cr * a20 / area;
		dgdy = cr * b20 / area;
		rr = COLOR_BASE * FIX_ONE + cr * w0r / area;
		gr = COLOR_BASE * FIX_ONE + cr * w1r / area;
		for (longint y = y0; y <= y1; y++) begin
			w0 = w0r; w1 = w1r; w2 = w2r; zf = zr; rf = rr; gf = gr;
			for (longint x = x0; x <= x1; x++) begin
				if (w0 >= 0 && w1 >= 0 && w2 >= 0 && zf >= 0) begin
					idx = int'(y * TILE + x);
					zq = zf / FIX_ONE;
					if (zq < longint'(depth_tile[idx])) begin
						r = rf[15:8];
						g = gf[15:8];
						b = 8'(COLOR_SUM - r - g);
						depth_tile[idx] = zq[15:0];
						color_tile[idx] = {r, g, b};
						count++;
					end
				end
				w0 += a12; w1 += a20; w2 += a01;
				zf += dzdx; rf += drdx; gf += dgdx;
			end
			w0r += b12; w1r += b20; w2r += b01;
			zr += dzdy; rr += drdy; gr += dgdy;
		end
	endtask

	// predict on each accepted request
	always @(posedge clk or negedge arst_n) begin
		pixel_result_t res;
		longint n;
		int col, row;
		if (!arst_n) begin
			clear_tile();
			result_q.delete();
		end else if (s_tvalid && s_tready) begin
			res = '0;
			case (op_t'(s_tuser))
				OP_CLEAR: clear_tile();
				OP_DRAW: begin
					rasterize(s_tdata, n);
					if (n < 0)
						res.skipped = 1'b1;
					else
						res.drawn = n[14:0];
				end
				OP_READ: begin
					col = s_tdata[150:144];
					row = s_tdata[157:151];
					if (col < TILE && row < TILE)
						{res.red, res.green, res.blue} = color_tile[row * TILE + col];
				end
				default: ;
			endcase
			result_q.push_back(res);
		end
	end

	// compare each accepted result
	initial errors = 0;
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				report("unexpected result", 0, 1);
			end else begin
				want = result_q.pop_front();
				if (m_tdata[7:0] !== want.red)
					report("pixel_red", want.red, m_tdata[7:0]);
				if (m_tdata[15:8] !== want.green)
					report("pixel_green", want.green, m_tdata[15:8]);
				if (m_tdata[23:16] !== want.blue)
					report("pixel_blue", want.blue, m_tdata[23:16]);
				if (m_tdata[38:24] !== want.drawn)
					report("pixels_drawn", want.drawn, m_tdata[38:24]);
				if (m_tuser[0] !== want.skipped)
					report("triangle_skipped", want.skipped, m_tuser[0]);
			end
		end
	end

endmodule

[dv/tb_triangle_raster_zbuffer_core.sv]
// ----------------------------------------------------------------------------
// Triangle raster z-buffer testbench
// Drives clear, draw, read and unused requests with random gaps and
// back-pressure; the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_triangle_raster_zbuffer_core;
	import trz_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT  = 4000000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata;
	logic [IN_USER_W-1:0]   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [OUT_USER_W-1:0]  m_tuser;
	int                     errors;
	int                     pending;
	int                     cycles;
	logic                   quiet;

	triangle_raster_zbuffer_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	triangle_raster_zbuffer_core_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 14);
	endfunction

	// random field values
	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic logic [6:0] rnd7();
		return 7'($urandom);
	endfunction

	// one request; valid stays high across back-to-back requests
	task automatic send(input op_t op, input logic [15:0] ax, input logic [15:0] ay,
			input logic [15:0] bx, input logic [15:0] by, input logic [15:0] cx,
			input logic [15:0] cy, input logic [15:0] za, input logic [15:0] zb,
			input logic [15:0] zc, input logic [6:0] col, input logic [6:0] row);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= op;
		s_tdata  <= {2'b0, row, col, zc, zb, za, cy, cx, by, bx, ay, ax};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_triangle(input int ax, input int ay, input int bx, input int by,
			input int cx, input int cy, input int za, input int zb, input int zc);
		send(OP_DRAW, ax[15:0], ay[15:0], bx[15:0], by[15:0], cx[15:0], cy[15:0],
			za[15:0], zb[15:0], zc[15:0], 7'd0, 7'd0);
	endtask

	task automatic send_read(input int col, input int row);
		send(OP_READ, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
			rnd16(), rnd16(), rnd16(), col[6:0], row[6:0]);
	endtask

	// result side back-pressure
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// stimulus
	initial begin
		int sel, bx0, by0, sz;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_NONE;
		quiet    = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed
		send_read(0, 0);
		send_read(127, 127);
		send(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F, 7'h7F);
		send_triangle(10, 10, 30, 10, 10, 30, 100, 200, 300);
		send_triangle(10, 10, 10, 30, 30, 10, 50, 50, 50);
		send_read(12, 12);
		send_triangle(5, 5, 6, 6, 7, 7, 0, 0, 0);
		send_triangle(0, 0, 1, 0, 0, 1, 0, 0, 0);
		send_triangle(-50, -50, -10, -50, -50, -10, 0, 0, 0);
		send_triangle(200, 200, 300, 200, 200, 300, 0, 0, 0);
		send_triangle(-32768, -32768, 32767, -32768, -32768, 32767, 0, 65535, 65535);
		send_read(64, 64);
		send_triangle(-20, 140, 140, 140, 60, -20, 0, 65535, 0);
		send_read(60, 100);
		send_triangle(20, 20, 100, 30, 40, 110, 65535, 65535, 65535);
		send_triangle(0, 0, 127, 0, 0, 127, 1, 0, 2);
		send_read(0, 0);
		send(OP_CLEAR, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
			7'd0, 7'd0);
		send_read(0, 0);

		// random
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 2) begin
				send(OP_CLEAR, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
					rnd16(), rnd16(), rnd16(), rnd7(), rnd7());
			end else if (sel < 5) begin
				send(OP_NONE, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
					rnd16(), rnd16(), rnd16(), rnd7(), rnd7());
			end else if (sel < 8) begin
				// full-range corners
				send(OP_DRAW, rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
					rnd16(), rnd16(), rnd16(), rnd7(), rnd7());
			end else if (sel < 55) begin
				bx0 = $urandom_range(0, 60) - 10;
				by0 = $urandom_range(0, 60) - 10;
				sz  = ($urandom_range(0, 9) == 0) ? 60 : 16;
				send_triangle(bx0 + $urandom_range(0, sz), by0 + $urandom_range(0, sz),
					bx0 + $urandom_range(0, sz), by0 + $urandom_range(0, sz),
					bx0 + $urandom_range(0, sz), by0 + $urandom_range(0, sz),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			end else if (sel < 90) begin
				send_read($urandom_range(0, 55), $urandom_range(0, 55));
			end else begin
				send_read($urandom_range(0, 127), $urandom_range(0, 127));
			end
		end
		s_tvalid <= 1'b0;

		// drain
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/trz_pkg.sv
sv/trz_ram.sv
sv/trz_div.sv
sv/triangle_raster_zbuffer_core.sv
dv/triangle_raster_zbuffer_core_checker.sv
dv/tb_triangle_raster_zbuffer_core.sv
